[hw/rtl/acs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants of the accumulator processor step block.
// ----------------------------------------------------------------------------
package acs_pkg;

	localparam int unsigned BYTE_SPAN = 256;
	localparam int unsigned DIV_STEPS = 8;

	localparam logic [7:0] OP_HLT = 8'd0;
	localparam logic [7:0] OP_LDA = 8'd1;
	localparam logic [7:0] OP_LDB = 8'd2;
	localparam logic [7:0] OP_ADD = 8'd3;
	localparam logic [7:0] OP_SUB = 8'd4;
	localparam logic [7:0] OP_MUL = 8'd5;
	localparam logic [7:0] OP_DIV = 8'd6;
	localparam logic [7:0] OP_AND = 8'd7;
	localparam logic [7:0] OP_OR  = 8'd8;
	localparam logic [7:0] OP_XOR = 8'd9;
	localparam logic [7:0] OP_CMP = 8'd10;
	localparam logic [7:0] OP_JMP = 8'd11;
	localparam logic [7:0] OP_JZ  = 8'd12;
	localparam logic [7:0] OP_JNZ = 8'd13;
	localparam logic [7:0] OP_PRN = 8'd14;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_HALT  = 2'd1,
		ST_DIV0  = 2'd2,
		ST_BADOP = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic rd_next;
		logic op_latch;
		logic div_init;
		logic div_step;
		logic commit;
	} acs_cmd_t;

	typedef struct packed {
		logic in_write;
		logic div_run;
		logic out_free;
	} acs_sts_t;

endpackage
`default_nettype wire

[hw/rtl/acs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acs_ctrl
// Controller: sequences input capture, opcode and operand fetch, the
// bit-serial divide and the commit of each word.
// ----------------------------------------------------------------------------
module acs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  acs_pkg::acs_sts_t sts,
	output acs_pkg::acs_cmd_t cmd
);
	import acs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DEC  = 4'b0010,
		S_DIV  = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	localparam logic [2:0] DIV_LAST = 3'(DIV_STEPS - 1);

	state_t     state_q, state_d;
	logic [2:0] div_cnt_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.rd_en  = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = sts.in_write ? S_EXEC : S_DEC;
				end
			end
			S_DEC: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_next  = 1'b1;
				cmd.op_latch = 1'b1;
				cmd.div_init = 1'b1;
				state_d      = sts.div_run ? S_DIV : S_EXEC;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 3'd1;
			end
		end
	end

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word accepted while another is in flight");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_LAST) |=> state_q == S_EXEC)
		else $error("divide did not finish after its last step");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

endmodule
`default_nettype wire

[hw/rtl/acs_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acs_dp
// Datapath: byte memory, processor registers, alu, bit-serial divider and
// the output register.
// ----------------------------------------------------------------------------
module acs_dp #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  acs_pkg::acs_cmd_t cmd,
	output acs_pkg::acs_sts_t sts,
	input  logic [15:0]       s_tdata,
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic              m_tuser
);
	import acs_pkg::*;

	localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [AW-1:0]        mod_tbl [BYTE_SPAN];
	logic [7:0]           mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [7:0]           rd_data_q;
	logic                 rd_vld_q;
	logic [7:0]           rd_word;
	logic [7:0]           rd_byte;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 mem_we;

	logic [7:0]  acc_q, b_q, pc_q, op_q;
	logic        zf_q, is_write_q;
	logic [7:0]  quo_q, rem_q;
	logic [8:0]  rem_sh, rem_diff;
	logic [15:0] prod;

	logic [7:0]  nx_acc, nx_b, nx_pc, alu_res, pc_p1, pc_p2;
	logic        nx_zf, nx_prn, alu;
	status_t     nx_st;

	logic        m_tvalid_q;
	status_t     out_st_q;
	logic        out_prn_q, out_zf_q;
	logic [7:0]  out_acc_q, out_pc_q;

	// address fold table, constant
	for (genvar g = 0; g < BYTE_SPAN; g++) begin : g_mod
		assign mod_tbl[g] = AW'(g % MEM_DEPTH);
	end

	assign pc_p1   = pc_q + 8'd1;
	assign pc_p2   = pc_q + 8'd2;
	assign mem_we  = cmd.capture && !s_tuser;
	assign wr_addr = mod_tbl[s_tdata[7:0]];
	assign rd_byte = cmd.rd_next ? pc_p1 : pc_q;
	assign rd_addr = mod_tbl[rd_byte];
	assign rd_word = rd_vld_q ? rd_data_q : 8'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= s_tdata[15:8];
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// unwritten entries read as zero (halt)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign rem_sh   = {rem_q, quo_q[7]};
	assign rem_diff = rem_sh - {1'b0, b_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q <= acc_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, b_q}) begin
				rem_q <= rem_diff[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= rem_sh[7:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign prod = 16'(acc_q) * 16'(b_q);

	always_comb begin
		nx_acc  = acc_q;
		nx_b    = b_q;
		nx_pc   = pc_p1;
		nx_zf   = zf_q;
		nx_st   = ST_OK;
		nx_prn  = 1'b0;
		alu     = 1'b0;
		alu_res = acc_q;
		if (is_write_q) begin
			nx_pc = pc_q;
		end else begin
			case (op_q)
				OP_HLT: begin
					nx_st = ST_HALT;
					nx_pc = pc_q;
				end
				OP_LDA: begin
					nx_acc = rd_word;
					nx_pc  = pc_p2;
				end
				OP_LDB: begin
					nx_b  = rd_word;
					nx_pc = pc_p2;
				end
				OP_ADD: begin
					alu     = 1'b1;
					alu_res = acc_q + b_q;
				end
				OP_SUB: begin
					alu     = 1'b1;
					alu_res = acc_q - b_q;
				end
				OP_MUL: begin
					alu     = 1'b1;
					alu_res = prod[7:0];
				end
				OP_DIV: begin
					alu = 1'b1;
					if (b_q == 8'd0) begin
						nx_st = ST_DIV0;
					end else begin
						alu_res = quo_q;
					end
				end
				OP_AND: begin
					alu     = 1'b1;
					alu_res = acc_q & b_q;
				end
				OP_OR: begin
					alu     = 1'b1;
					alu_res = acc_q | b_q;
				end
				OP_XOR: begin
					alu     = 1'b1;
					alu_res = acc_q ^ b_q;
				end
				OP_CMP: begin
					nx_zf = (acc_q == b_q);
				end
				OP_JMP: begin
					nx_pc = rd_word;
				end
				OP_JZ: begin
					nx_pc = zf_q ? rd_word : pc_p2;
				end
				OP_JNZ: begin
					nx_pc = zf_q ? pc_p2 : rd_word;
				end
				OP_PRN: begin
					nx_prn = 1'b1;
				end
				default: begin
					nx_st = ST_BADOP;
					nx_pc = pc_q;
				end
			endcase
			if (alu) begin
				nx_acc = alu_res;
				nx_zf  = (alu_res == 8'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			b_q        <= '0;
			pc_q       <= '0;
			zf_q       <= 1'b0;
			is_write_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				is_write_q <= !s_tuser;
			end
			if (cmd.commit) begin
				acc_q      <= nx_acc;
				b_q        <= nx_b;
				pc_q       <= nx_pc;
				zf_q       <= nx_zf;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_latch) begin
			op_q <= rd_word;
		end
		if (cmd.commit) begin
			out_st_q  <= nx_st;
			out_prn_q <= nx_prn;
			out_acc_q <= nx_acc;
			out_zf_q  <= nx_zf;
			out_pc_q  <= nx_pc;
		end
	end

	assign sts.in_write = !s_tuser;
	assign sts.div_run  = (rd_word == OP_DIV) && (b_q != 8'd0);
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_prn_q;
	assign m_tdata  = {5'd0, out_pc_q, out_zf_q, out_acc_q, out_st_q};

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a word not yet taken");

	a_write_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_write_q) |=>
		(acc_q == $past(acc_q) && pc_q == $past(pc_q) && zf_q == $past(zf_q)))
		else $error("memory write changed processor state");

	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !is_write_q && op_q == OP_HLT) |=> pc_q == $past(pc_q))
		else $error("halt moved the program counter");

endmodule
`default_nettype wire

[hw/rtl/accumulator_cpu_step.sv]
`default_nettype none
// a memory write word is captured then committed; a step word also passes
// a decode state for the registered reads of opcode and operand; a divide
// with non-zero divisor also runs the divider, one quotient bit a cycle;
// one word at a time, commit waits for a free output; reset clears the
// processor registers, output valid and memory valid bits
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Top level of the 8-bit accumulator processor step block.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // address, data
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status, acc_value, zero_out, pc_out
	output logic        m_tuser    // print_valid
);
	import acs_pkg::*;

	acs_cmd_t cmd;
	acs_sts_t sts;

	acs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acs_dp #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
